### rtl/twq_pkg.sv
// Shared constants, codes and control types of the thread wait queue.
package twq_pkg;

	localparam int NUM_THREADS = 16;
	localparam int TID_W       = 4;
	localparam int IDX_W       = (NUM_THREADS > 1) ? $clog2(NUM_THREADS) : 1;
	localparam int CNT_W       = $clog2(NUM_THREADS + 1);

	typedef enum logic [1:0] {
		MODE_PUSH   = 2'd0,
		MODE_POP    = 2'd1,
		MODE_REMOVE = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_ABSENT = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_FETCH,
		S_LINK,
		S_DONE
	} state_t;

	// Events from the datapath to the sequencer.
	typedef struct packed {
		logic accept;
		logic unlink;
		logic out_free;
	} twq_ev_t;

	// Step strobes from the sequencer to the datapath.
	typedef struct packed {
		logic idle;
		logic fetch;
		logic link;
		logic load;
	} twq_cmd_t;

endpackage

### rtl/twq_if.sv
// Request and response channel interfaces of the thread wait queue.
interface twq_req_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               mode;
	logic [twq_pkg::TID_W-1:0] thread_id;

	modport source (output valid, output mode, output thread_id, input ready);
	modport sink   (input valid, input mode, input thread_id, output ready);
endinterface

interface twq_rsp_if;
	logic                     valid;
	logic                     ready;
	logic [1:0]               status;
	logic                     head_valid;
	logic [twq_pkg::TID_W-1:0] head_id;
	logic [twq_pkg::CNT_W-1:0] count;

	modport source (output valid, output status, output head_valid, output head_id,
		output count, input ready);
	modport sink   (input valid, input status, input head_valid, input head_id,
		input count, output ready);
endinterface

### rtl/twq_ram.sv
// Generic single write port RAM with one registered read port.
module twq_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/twq_ctrl.sv
// Sequencer that steps one queue operation through fetch, link and result load.
module twq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  twq_pkg::twq_ev_t  ev,
	output twq_pkg::twq_cmd_t cmd
);

	twq_pkg::state_t state_q;
	twq_pkg::state_t state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			twq_pkg::S_IDLE:  if (ev.accept) state_d = twq_pkg::S_FETCH;
			twq_pkg::S_FETCH: state_d = ev.unlink ? twq_pkg::S_LINK : twq_pkg::S_DONE;
			twq_pkg::S_LINK:  state_d = twq_pkg::S_DONE;
			twq_pkg::S_DONE:  if (ev.out_free) state_d = twq_pkg::S_IDLE;
			default:          state_d = twq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			twq_pkg::S_IDLE:  cmd.idle  = 1'b1;
			twq_pkg::S_FETCH: cmd.fetch = 1'b1;
			twq_pkg::S_LINK:  cmd.link  = 1'b1;
			twq_pkg::S_DONE:  cmd.load  = ev.out_free;
			default:          cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= twq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

### rtl/thread_wait_queue_with_removal_core.sv
// Top level of the thread wait queue: queue registers, link tables and result register.
//
// FIFO wait queue of thread identifiers held as a doubly linked list. Each request word
// pushes thread_id at the tail, pops the head, or removes thread_id from anywhere in the
// queue, and returns one response word with a status (ok, empty underflow, not in queue,
// already queued), the head after the operation and the count after the operation. The
// next and previous links sit in two small RAMs with one write port and a registered
// read port each; a membership bit per thread, cleared at reset, answers whether a thread
// is queued. A request is taken only while the sequencer is idle. Push, rejected
// operations and the unused mode step through idle, fetch and result load, and pop and
// remove add a link step between fetch and result load, because unlinking must first
// read the leaving thread's links through the registered RAM port and then write the
// neighbours' links through the single write port. The response appears in the output
// register in the cycle after the load step and may wait there while the block
// accepts the next request; a request whose result finds that register still full holds
// in its load step until the response word is taken. Reset needs no clearing pass: the
// link tables are only read for queued threads, and every push writes the links it needs.
module thread_wait_queue_with_removal_core (
	input  logic            clk,
	input  logic            arst_n,
	twq_req_if.sink         req,
	twq_rsp_if.source       rsp
);

	localparam int TW = twq_pkg::TID_W;
	localparam int IW = twq_pkg::IDX_W;
	localparam int CW = twq_pkg::CNT_W;

	twq_pkg::twq_ev_t  ev;
	twq_pkg::twq_cmd_t cmd;

	// Latched request
	twq_pkg::mode_t mode_q;
	logic [TW-1:0]  tid_q;

	// Queue state
	logic [twq_pkg::NUM_THREADS-1:0] flags_q;
	logic [TW-1:0]                   head_q;
	logic [TW-1:0]                   tail_q;
	logic [CW-1:0]                   count_q;

	// Operation bookkeeping between fetch and link
	twq_pkg::status_t status_q;
	logic [TW-1:0]    target_q;

	// Response register
	logic             out_valid_q;
	twq_pkg::status_t out_status_q;
	logic             out_head_valid_q;
	logic [TW-1:0]    out_head_id_q;
	logic [CW-1:0]    out_count_q;

	// Link table ports
	logic          nx_we, pv_we;
	logic [IW-1:0] nx_waddr, pv_waddr, rd_addr;
	logic [TW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;

	logic             accept;
	logic             in_range;
	logic             is_queued;
	logic [TW-1:0]    target;
	twq_pkg::status_t status_d;
	logic             push_go;

	assign accept      = req.valid && req.ready;
	assign req.ready   = cmd.idle;
	assign ev.accept   = accept;
	assign ev.out_free = !out_valid_q || rsp.ready;

	assign in_range  = 32'(tid_q) < twq_pkg::NUM_THREADS;
	assign is_queued = in_range && flags_q[IW'(tid_q)];
	assign target    = (mode_q == twq_pkg::MODE_POP) ? head_q : tid_q;

	// Decide the status of the held request.
	always_comb begin
		status_d = twq_pkg::ST_OK;
		unique case (mode_q)
			twq_pkg::MODE_PUSH: begin
				if (!in_range) status_d = twq_pkg::ST_ABSENT;
				else if (is_queued) status_d = twq_pkg::ST_DUP;
			end
			twq_pkg::MODE_POP: begin
				if (count_q == '0) status_d = twq_pkg::ST_EMPTY;
			end
			twq_pkg::MODE_REMOVE: begin
				if (count_q == '0) status_d = twq_pkg::ST_EMPTY;
				else if (!is_queued) status_d = twq_pkg::ST_ABSENT;
			end
			default: status_d = twq_pkg::ST_OK;
		endcase
	end

	assign push_go   = (mode_q == twq_pkg::MODE_PUSH) && (status_d == twq_pkg::ST_OK);
	assign ev.unlink = ((mode_q == twq_pkg::MODE_POP) || (mode_q == twq_pkg::MODE_REMOVE))
		&& (status_d == twq_pkg::ST_OK);

	// Read both links of the target during fetch; the data is ready in the link step.
	assign rd_addr = IW'(target);

	// Link table writes. Push writes during fetch, unlink writes the neighbours during link.
	// The leaving thread's own links are never followed and are left as they are; a fresh
	// tail's next link is written only when the tail enters an empty queue.
	always_comb begin
		nx_we    = 1'b0;
		nx_waddr = IW'(tail_q);
		nx_wdata = tid_q;
		pv_we    = 1'b0;
		pv_waddr = IW'(tid_q);
		pv_wdata = (count_q == '0) ? '0 : tail_q;
		if (cmd.fetch && push_go) begin
			pv_we = 1'b1;
			nx_we = 1'b1;
			if (count_q == '0) begin
				nx_waddr = IW'(tid_q);
				nx_wdata = '0;
			end
		end else if (cmd.link && (count_q > CW'(1))) begin
			nx_waddr = IW'(pv_rdata);
			pv_waddr = IW'(nx_rdata);
			priority if (target_q == head_q) begin
				pv_we    = 1'b1;
				pv_wdata = '0;
			end else if (target_q == tail_q) begin
				nx_we    = 1'b1;
				nx_wdata = '0;
			end else begin
				nx_we    = 1'b1;
				nx_wdata = nx_rdata;
				pv_we    = 1'b1;
				pv_wdata = pv_rdata;
			end
		end
	end

	twq_ram #(.WIDTH(TW), .DEPTH(twq_pkg::NUM_THREADS)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_waddr),
		.wdata (nx_wdata),
		.raddr (rd_addr),
		.rdata (nx_rdata)
	);

	twq_ram #(.WIDTH(TW), .DEPTH(twq_pkg::NUM_THREADS)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_waddr),
		.wdata (pv_wdata),
		.raddr (rd_addr),
		.rdata (pv_rdata)
	);

	twq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.ev     (ev),
		.cmd    (cmd)
	);

	// Hold the request word, and the status and target at the fetch step.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= twq_pkg::mode_t'(req.mode);
			tid_q  <= req.thread_id;
		end
		if (cmd.fetch) begin
			status_q <= status_d;
			target_q <= target;
		end
	end

	// Queue pointers, count and membership bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (cmd.fetch && push_go) begin
			if (count_q == '0) begin
				head_q <= tid_q;
			end
			tail_q               <= tid_q;
			flags_q[IW'(tid_q)]  <= 1'b1;
			count_q              <= count_q + CW'(1);
		end else if (cmd.link) begin
			if (count_q <= CW'(1)) begin
				head_q <= '0;
				tail_q <= '0;
			end else if (target_q == head_q) begin
				head_q <= nx_rdata;
			end else if (target_q == tail_q) begin
				tail_q <= pv_rdata;
			end
			flags_q[IW'(target_q)] <= 1'b0;
			count_q                <= count_q - CW'(1);
		end
	end

	// Response register: load on the final step, drop when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_status_q     <= status_q;
			out_head_valid_q <= (count_q != '0);
			out_head_id_q    <= (count_q != '0) ? head_q : '0;
			out_count_q      <= count_q;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = out_status_q;
	assign rsp.head_valid = out_head_valid_q;
	assign rsp.head_id    = out_head_id_q;
	assign rsp.count      = out_count_q;

	// Membership bits and the count must agree.
	a_count_matches_flags: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) == $countones(flags_q))
		else $error("queue count disagrees with membership bits");

	// An empty queue parks both pointers at zero.
	a_empty_pointers: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0) && (tail_q == '0))
		else $error("pointers not cleared on empty queue");

	// A non-empty queue has its head and tail queued.
	a_ends_queued: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> flags_q[IW'(head_q)] && flags_q[IW'(tail_q)])
		else $error("head or tail not marked as queued");

	// A load always presents a response the next cycle.
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> rsp.valid)
		else $error("response register not loaded");

	// No request is taken while an operation is in flight.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.fetch || cmd.link) |-> !req.ready)
		else $error("request accepted during an operation");

endmodule
